### rtl/core/psm_pkg.sv
package psm_pkg;

	localparam int COORD_W = 12;             // input coordinate width
	localparam int REL_W   = COORD_W + 1;    // coordinate relative to center
	localparam int CROSS_W = 2 * REL_W;      // signed cross product
	localparam int ABS_W   = CROSS_W;        // |cross|, kept signed-positive
	localparam int QSQ_W   = 2 * REL_W + 1;  // xx / yy quadratic term, signed
	localparam int QXY_W   = 2 * REL_W + 2;  // xy quadratic term, signed
	localparam int MA_W    = QXY_W;          // multiplier operand A
	localparam int MB_W    = ABS_W;          // multiplier operand B
	localparam int PROD_W  = MA_W + MB_W;    // registered product
	localparam int SQ_W    = 63;             // unsigned moment width
	localparam int SXY_W   = 64;             // signed moment width

	localparam logic [3:0] LAST_ISSUE = 4'd12;
	localparam logic [3:0] LAST_STEP  = 4'd13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_EMIT
	} state_t;

	// One code for each product issued to the shared multiplier
	typedef enum logic [3:0] {
		OP_NONE,
		OP_X1Y2,
		OP_X2Y1,
		OP_X1X1,
		OP_X1X2,
		OP_X2X2,
		OP_Y1Y1,
		OP_Y1Y2,
		OP_Y2Y2,
		OP_X1Y1,
		OP_X2Y2,
		OP_AXX,
		OP_AYY,
		OP_AXY
	} op_t;

	function automatic op_t step_op(input logic [3:0] step);
		op_t op;
		unique case (step)
			4'd0:    op = OP_X1Y2;
			4'd1:    op = OP_X2Y1;
			4'd2:    op = OP_X1X1;
			4'd3:    op = OP_X1X2;
			4'd4:    op = OP_X2X2;
			4'd5:    op = OP_Y1Y1;
			4'd6:    op = OP_Y1Y2;
			4'd7:    op = OP_Y2Y2;
			4'd8:    op = OP_X1Y1;
			4'd9:    op = OP_X2Y2;
			4'd10:   op = OP_AXX;
			4'd11:   op = OP_AYY;
			4'd12:   op = OP_AXY;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

### rtl/core/psm_edge_if.sv
interface psm_edge_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [psm_pkg::COORD_W-1:0]   p1_x;
	logic signed [psm_pkg::COORD_W-1:0]   p1_y;
	logic signed [psm_pkg::COORD_W-1:0]   p2_x;
	logic signed [psm_pkg::COORD_W-1:0]   p2_y;
	logic signed [psm_pkg::COORD_W-1:0]   center_x;
	logic signed [psm_pkg::COORD_W-1:0]   center_y;
	logic                                 last_edge;

	modport source (
		output valid, p1_x, p1_y, p2_x, p2_y, center_x, center_y, last_edge,
		input  ready
	);
	modport sink (
		input  valid, p1_x, p1_y, p2_x, p2_y, center_x, center_y, last_edge,
		output ready
	);
endinterface

### rtl/core/psm_moment_if.sv
interface psm_moment_if;
	logic                               valid;
	logic                               ready;
	logic        [psm_pkg::SQ_W-1:0]    moment_xx;
	logic signed [psm_pkg::SXY_W-1:0]   moment_xy;
	logic        [psm_pkg::SQ_W-1:0]    moment_yy;

	modport source (
		output valid, moment_xx, moment_xy, moment_yy,
		input  ready
	);
	modport sink (
		input  valid, moment_xx, moment_xy, moment_yy,
		output ready
	);
endinterface

### rtl/core/psm_mul.sv
module psm_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [psm_pkg::MA_W-1:0]     op_a,
	input  logic signed [psm_pkg::MB_W-1:0]     op_b,
	output logic signed [psm_pkg::PROD_W-1:0]   prod_s1
);
	import psm_pkg::*;

	logic signed [PROD_W-1:0] prod;

	assign prod = PROD_W'(op_a) * PROD_W'(op_b);

	// hold the product until the next issue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end
endmodule

### rtl/core/polygon_second_moment.sv
// Channel   Dir  Beat contents
// --------  ---  -----------------------------------------------------------
// edges     in   p1_x, p1_y, p2_x, p2_y, center_x, center_y, last_edge
// moments   out  moment_xx (12*Ixx), moment_xy (24*Ixy), moment_yy (12*Iyy)
//
// Each edge beat sends 13 products through one shared signed 28x26
// multiplier, then folds in the last product, and ready returns the cycle
// after. A last_edge beat also moves the sums into the output register,
// waiting while that register still holds an untaken beat. arst_n clears the
// sequencer, accumulators and output valid. A stalled output holds back only
// the next last_edge beat; the other edge beats of the next polygon go on.
module polygon_second_moment (
	input  logic          clk,
	input  logic          arst_n,
	psm_edge_if.sink      edges,
	psm_moment_if.source  moments
);
	import psm_pkg::*;

	state_t state_q, state_d;
	logic [3:0] cnt_q;

	// relative coordinates of the edge in flight
	logic signed [REL_W-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic                     last_q;

	// per-edge partial terms
	logic signed [CROSS_W-1:0] cross_q;
	logic signed [QSQ_W-1:0]   qxx_q, qyy_q;
	logic signed [QXY_W-1:0]   qxy_q;

	// polygon accumulators
	logic [SQ_W-1:0]           sum_xx_q, sum_yy_q;
	logic signed [SXY_W-1:0]   sum_xy_q;

	// output register
	logic                      out_valid_q;
	logic [SQ_W-1:0]           mxx_q, myy_q;
	logic signed [SXY_W-1:0]   mxy_q;

	logic                      accept, issue, load_out, out_free;
	op_t                       op_now, op_s1;
	logic signed [MA_W-1:0]    op_a;
	logic signed [MB_W-1:0]    op_b;
	logic signed [ABS_W-1:0]   abs_a;
	logic signed [PROD_W-1:0]  prod_s1;

	logic [SQ_W:0]             add_xx, add_yy;
	logic signed [SXY_W:0]     add_xy;

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || moments.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edges.ready  = 1'b0;
		issue        = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				edges.ready = 1'b1;
				if (edges.valid) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				issue = (cnt_q <= LAST_ISSUE);
				if (cnt_q == LAST_STEP) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = edges.valid && edges.ready;
	assign op_now = issue ? step_op(cnt_q) : OP_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_s1 <= OP_NONE;
		end else begin
			cnt_q <= (state_q == ST_BUSY) ? cnt_q + 4'd1 : 4'd0;
			op_s1 <= op_now;
		end
	end

	// capture the edge relative to the center; 13 bits never wrap
	always_ff @(posedge clk) begin
		if (accept) begin
			x1_q   <= REL_W'(edges.p1_x) - REL_W'(edges.center_x);
			y1_q   <= REL_W'(edges.p1_y) - REL_W'(edges.center_y);
			x2_q   <= REL_W'(edges.p2_x) - REL_W'(edges.center_x);
			y2_q   <= REL_W'(edges.p2_y) - REL_W'(edges.center_y);
			last_q <= edges.last_edge;
		end
	end

	// ---------------- shared multiplier ----------------
	assign abs_a = cross_q[CROSS_W-1] ? -cross_q : cross_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (op_now)
			OP_X1Y2: begin op_a = MA_W'(x1_q);  op_b = MB_W'(y2_q);  end
			OP_X2Y1: begin op_a = MA_W'(x2_q);  op_b = MB_W'(y1_q);  end
			OP_X1X1: begin op_a = MA_W'(x1_q);  op_b = MB_W'(x1_q);  end
			OP_X1X2: begin op_a = MA_W'(x1_q);  op_b = MB_W'(x2_q);  end
			OP_X2X2: begin op_a = MA_W'(x2_q);  op_b = MB_W'(x2_q);  end
			OP_Y1Y1: begin op_a = MA_W'(y1_q);  op_b = MB_W'(y1_q);  end
			OP_Y1Y2: begin op_a = MA_W'(y1_q);  op_b = MB_W'(y2_q);  end
			OP_Y2Y2: begin op_a = MA_W'(y2_q);  op_b = MB_W'(y2_q);  end
			OP_X1Y1: begin op_a = MA_W'(x1_q);  op_b = MB_W'(y1_q);  end
			OP_X2Y2: begin op_a = MA_W'(x2_q);  op_b = MB_W'(y2_q);  end
			OP_AXX:  begin op_a = MA_W'(qxx_q); op_b = abs_a;        end
			OP_AYY:  begin op_a = MA_W'(qyy_q); op_b = abs_a;        end
			OP_AXY:  begin op_a = qxy_q;        op_b = abs_a;        end
			default: begin op_a = '0;           op_b = '0;           end
		endcase
	end

	psm_mul u_mul (
		.clk     (clk),
		.en      (issue),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	// ---------------- accumulate ----------------
	// products of the final three steps are below 2^52 in magnitude
	assign add_xx = {1'b0, sum_xx_q} + (SQ_W+1)'(prod_s1[PROD_W-2:0]);
	assign add_yy = {1'b0, sum_yy_q} + (SQ_W+1)'(prod_s1[PROD_W-2:0]);
	assign add_xy = (SXY_W+1)'(sum_xy_q) + (SXY_W+1)'(prod_s1);

	// fold the registered product into its term
	always_ff @(posedge clk) begin
		case (op_s1)
			OP_X1Y2: begin
				cross_q <= prod_s1[CROSS_W-1:0];
				qxy_q   <= prod_s1[QXY_W-1:0];
			end
			OP_X2Y1: begin
				cross_q <= cross_q - prod_s1[CROSS_W-1:0];
				qxy_q   <= qxy_q + prod_s1[QXY_W-1:0];
			end
			OP_X1X1: qxx_q <= prod_s1[QSQ_W-1:0];
			OP_X1X2, OP_X2X2: qxx_q <= qxx_q + prod_s1[QSQ_W-1:0];
			OP_Y1Y1: qyy_q <= prod_s1[QSQ_W-1:0];
			OP_Y1Y2, OP_Y2Y2: qyy_q <= qyy_q + prod_s1[QSQ_W-1:0];
			OP_X1Y1, OP_X2Y2: qxy_q <= qxy_q + {prod_s1[QXY_W-2:0], 1'b0};
			default: ;
		endcase
	end

	// polygon sums saturate; xx and yy stay saturated until emitted, xy can move back off its limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else if (load_out) begin
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
		end else begin
			case (op_s1)
				OP_AXX: sum_xx_q <= add_xx[SQ_W] ? {SQ_W{1'b1}} : add_xx[SQ_W-1:0];
				OP_AYY: sum_yy_q <= add_yy[SQ_W] ? {SQ_W{1'b1}} : add_yy[SQ_W-1:0];
				OP_AXY: begin
					if (add_xy[SXY_W] != add_xy[SXY_W-1]) begin
						sum_xy_q <= add_xy[SXY_W] ? {1'b1, {(SXY_W-1){1'b0}}}
						                          : {1'b0, {(SXY_W-1){1'b1}}};
					end else begin
						sum_xy_q <= add_xy[SXY_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (moments.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mxx_q <= sum_xx_q;
			mxy_q <= sum_xy_q;
			myy_q <= sum_yy_q;
		end
	end

	assign moments.valid     = out_valid_q;
	assign moments.moment_xx = mxx_q;
	assign moments.moment_xy = mxy_q;
	assign moments.moment_yy = myy_q;
endmodule
